[design/egl_pkg.sv]
// Shared types and constants for the GCD / LCM unit.
// Used by egl_arith_unit and euclid_gcd_lcm_unit; no dependencies.
`timescale 1ns / 1ps

package egl_pkg;

  // Operand and result width.
  localparam int DATA_WIDTH = 31;

  // Request payload: the two operands.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] first_value;
    logic [DATA_WIDTH-1:0] second_value;
  } egl_in_t;

  // Result payload.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] common_multiple;
    logic [DATA_WIDTH-1:0] common_divisor;
    logic                  overflow;
  } egl_out_t;

  // Operations of the shared serial arithmetic unit.
  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } egl_op_t;

  // Command from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    go;
    egl_op_t op;
  } egl_cmd_t;

endpackage

[design/egl_arith_unit.sv]
// Bit-serial divide / multiply unit sharing one adder-subtractor.
// Depends on egl_pkg for the command type.
`timescale 1ns / 1ps

module egl_arith_unit #(
  parameter int WIDTH = egl_pkg::DATA_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  egl_pkg::egl_cmd_t   cmd,
  input  logic [WIDTH-1:0]    opa,
  input  logic [WIDTH-1:0]    opb,
  output logic                done,
  output logic [WIDTH-1:0]    res_hi,
  output logic [WIDTH-1:0]    res_lo
);
  import egl_pkg::*;

  localparam int CNT_W = $clog2(WIDTH + 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Working registers: hi holds the remainder or upper product half,
  // lo holds the quotient or lower product half.
  logic [WIDTH-1:0] hi_r, hi_nxt;
  logic [WIDTH-1:0] lo_r, lo_nxt;
  logic [WIDTH-1:0] opd_r;
  egl_op_t          op_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [WIDTH:0]   add_a;
  logic [WIDTH:0]   add_b;
  logic             add_cin;
  logic [WIDTH+1:0] sum;
  logic [WIDTH:0]   trial;

  // One shared adder: subtracts for a divide step, adds for a multiply step.
  always_comb begin
    trial = {hi_r, lo_r[WIDTH-1]};
    if (op_r == OP_DIV) begin
      add_a   = trial;
      add_b   = ~{1'b0, opd_r};
      add_cin = 1'b1;
    end else begin
      add_a   = {1'b0, hi_r};
      add_b   = lo_r[0] ? {1'b0, opd_r} : '0;
      add_cin = 1'b0;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {{(WIDTH + 1){1'b0}}, add_cin};
  end

  // Next value of the working registers for one step.
  always_comb begin
    if (op_r == OP_DIV) begin
      // Carry out set means no borrow: the trial remainder covers the divisor.
      if (sum[WIDTH+1]) begin
        hi_nxt = sum[WIDTH-1:0];
      end else begin
        hi_nxt = trial[WIDTH-1:0];
      end
      lo_nxt = {lo_r[WIDTH-2:0], sum[WIDTH+1]};
    end else begin
      hi_nxt = sum[WIDTH:1];
      lo_nxt = {sum[0], lo_r[WIDTH-1:1]};
    end
  end

  // Step counter and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_ONE;
        if (cnt_r == CNT_ONE) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      hi_r  <= '0;
      lo_r  <= opa;
      opd_r <= opb;
      op_r  <= cmd.op;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign done   = done_r;
  assign res_hi = hi_r;
  assign res_lo = lo_r;

endmodule

[design/euclid_gcd_lcm_unit.sv]
// Top level of the GCD / LCM unit: request handshake and Euclid sequencer.
// Depends on egl_pkg and egl_arith_unit.
`timescale 1ns / 1ps

// Usage
//   A request (in_req: first_value, second_value) is taken on a rising edge
//   where start is high and busy is low. busy stays high until the cycle in
//   which the result is shown; no new request is taken meanwhile.
//   The result (out_res: common_multiple, common_divisor, overflow) is shown
//   for exactly one cycle with out_valid high. The receiver cannot stall it,
//   so it must capture the result in that cycle.
//   Every division or multiplication runs on one shared bit-serial unit.
//   A request with N Euclid remainder steps runs N division passes, then
//   the quotient pass and the final multiply before its result is shown;
//   N is at most about 46 for 31-bit operands. If an operand is zero, no
//   pass runs on the unit and a multiple of 0 is shown straight from the
//   Euclid check state.
//   Throughput: the next request can be taken at the edge that ends the
//   result cycle. A multiple that does not fit saturates to all ones with
//   overflow set. Reset (rst_n low, synchronous) returns the sequencer to
//   idle and clears the dividend and divisor registers; no result is pending.
module euclid_gcd_lcm_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  egl_pkg::egl_in_t  in_req,
  output logic              out_valid,
  output egl_pkg::egl_out_t out_res
);
  import egl_pkg::*;

  localparam int W = DATA_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_REM,
    ST_QUO,
    ST_MUL
  } state_t;

  state_t        state_r;
  logic [W-1:0]  big_r;
  logic [W-1:0]  small_r;
  logic [W-1:0]  dividend_r;
  logic [W-1:0]  divisor_r;
  logic          out_valid_r;
  egl_out_t      out_res_r;

  egl_cmd_t      cmd;
  logic [W-1:0]  opa;
  logic [W-1:0]  opb;
  logic          unit_done;
  logic [W-1:0]  unit_hi;
  logic [W-1:0]  unit_lo;

  logic          a_gt_b;

  assign a_gt_b = in_req.first_value > in_req.second_value;

  // Command to the arithmetic unit, issued from the Euclid check state
  // and after the quotient pass.
  always_comb begin
    cmd.go = 1'b0;
    cmd.op = OP_DIV;
    opa    = dividend_r;
    opb    = divisor_r;
    unique case (state_r)
      ST_GCD: begin
        if (divisor_r != '0) begin
          cmd.go = 1'b1;
        end else if (dividend_r != '0 && small_r != '0) begin
          cmd.go = 1'b1;
          opa    = big_r;
          opb    = dividend_r;
        end
      end
      ST_QUO: begin
        if (unit_done) begin
          cmd.go = 1'b1;
          cmd.op = OP_MUL;
          opa    = unit_lo;
          opb    = small_r;
        end
      end
      ST_IDLE, ST_REM, ST_MUL: begin
        cmd.go = 1'b0;
      end
      default: begin
        cmd.go = 1'b0;
      end
    endcase
  end

  // Sequencer with registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dividend_r  <= '0;
      divisor_r   <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            // Order the pair as larger and smaller.
            if (a_gt_b) begin
              big_r      <= in_req.first_value;
              small_r    <= in_req.second_value;
              dividend_r <= in_req.first_value;
              divisor_r  <= in_req.second_value;
            end else begin
              big_r      <= in_req.second_value;
              small_r    <= in_req.first_value;
              dividend_r <= in_req.second_value;
              divisor_r  <= in_req.first_value;
            end
            state_r <= ST_GCD;
          end
        end
        ST_GCD: begin
          if (divisor_r != '0) begin
            state_r <= ST_REM;
          end else if (dividend_r != '0 && small_r != '0) begin
            state_r <= ST_QUO;
          end else begin
            // Zero operand: the multiple is zero.
            out_res_r.common_multiple <= '0;
            out_res_r.common_divisor  <= dividend_r;
            out_res_r.overflow        <= 1'b0;
            out_valid_r               <= 1'b1;
            state_r                   <= ST_IDLE;
          end
        end
        ST_REM: begin
          if (unit_done) begin
            dividend_r <= divisor_r;
            divisor_r  <= unit_hi;
            state_r    <= ST_GCD;
          end
        end
        ST_QUO: begin
          if (unit_done) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (unit_done) begin
            // Any bit in the upper product half means the multiple overflows.
            if (unit_hi != '0) begin
              out_res_r.common_multiple <= '1;
              out_res_r.overflow        <= 1'b1;
            end else begin
              out_res_r.common_multiple <= unit_lo;
              out_res_r.overflow        <= 1'b0;
            end
            out_res_r.common_divisor <= dividend_r;
            out_valid_r              <= 1'b1;
            state_r                  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  egl_arith_unit #(
    .WIDTH (W)
  ) u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .opa    (opa),
    .opb    (opb),
    .done   (unit_done),
    .res_hi (unit_hi),
    .res_lo (unit_lo)
  );

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

[sim/egl_result_checker.sv]
// Result checker for the GCD / LCM unit: predicts the result of every
// accepted request and compares it with what the unit issues. Depends on egl_pkg.
`timescale 1ns / 1ps

module egl_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  egl_pkg::egl_in_t  in_req,
  input  logic              out_valid,
  input  egl_pkg::egl_out_t out_res,
  output int                fail_count,
  output int                pending_count,
  output int                result_count,
  output int                overflow_count
);
  import egl_pkg::*;

  localparam logic [63:0] VALUE_MAX    = (64'd1 << DATA_WIDTH) - 64'd1;
  localparam int          REPORT_LIMIT = 10;

  // Results still owed by the unit, oldest first.
  egl_out_t owed_results[$];
  int       errors;
  int       results;
  int       overflows;

  // Euclid's remainder steps on the ordered pair, then the multiple as
  // (larger / divisor) * smaller, saturated when it leaves the value range.
  function automatic egl_out_t predict_lcm_gcd(egl_in_t req);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] larger;
    logic [63:0] little;
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic [63:0] remainder;
    logic [63:0] quotient;
    logic [63:0] product;
    egl_out_t    res;
    a = 64'(req.first_value);
    b = 64'(req.second_value);
    if (a > b) begin
      larger = a;
      little = b;
    end else begin
      larger = b;
      little = a;
    end
    dividend = larger;
    divisor  = little;
    while (divisor != 64'd0) begin
      remainder = dividend % divisor;
      dividend  = divisor;
      divisor   = remainder;
    end
    res.common_divisor = dividend[DATA_WIDTH-1:0];
    res.overflow       = 1'b0;
    // A zero operand gives a zero multiple and no overflow.
    if (dividend == 64'd0 || little == 64'd0) begin
      res.common_multiple = '0;
    end else begin
      quotient = larger / dividend;
      if (quotient > VALUE_MAX / little) begin
        res.common_multiple = '1;
        res.overflow        = 1'b1;
      end else begin
        product             = quotient * little;
        res.common_multiple = product[DATA_WIDTH-1:0];
      end
    end
    return res;
  endfunction

  // Compare each issued result with the oldest owed one, then record any
  // request taken on this edge.
  always @(posedge clk) begin : monitor
    egl_out_t owed;
    if (rst_n) begin
      if (out_valid) begin
        results++;
        if (out_res.overflow) overflows++;
        if (owed_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: result with no request pending: multiple %0d divisor %0d ovf %0b",
                     $realtime, out_res.common_multiple, out_res.common_divisor,
                     out_res.overflow);
        end else begin
          owed = owed_results.pop_front();
          if (out_res.common_multiple !== owed.common_multiple ||
              out_res.common_divisor  !== owed.common_divisor  ||
              out_res.overflow        !== owed.overflow) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t: mismatch: multiple exp %0d got %0d, divisor exp %0d got %0d, ovf exp %0b got %0b",
                       $realtime, owed.common_multiple, out_res.common_multiple,
                       owed.common_divisor, out_res.common_divisor,
                       owed.overflow, out_res.overflow);
          end
        end
      end
      if (start && !busy) owed_results.push_back(predict_lcm_gcd(in_req));
    end
    fail_count     <= errors;
    pending_count  <= owed_results.size();
    result_count   <= results;
    overflow_count <= overflows;
  end

endmodule

[sim/tb_top.sv]
// Testbench top for the GCD / LCM unit: clock, reset, request stimulus,
// watchdog and verdict. Depends on egl_pkg, euclid_gcd_lcm_unit, egl_result_checker.
`timescale 1ns / 1ps

module tb_top;
  import egl_pkg::*;

  localparam logic [DATA_WIDTH-1:0] VALUE_MAX     = '1;
  localparam int                    RANDOM_ITEMS  = 400;
  localparam int                    STALL_LIMIT   = 20000;
  localparam int                    DRAIN_CYCLES  = 2000;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  egl_in_t  in_req;
  logic     out_valid;
  egl_out_t out_res;

  int fail_count;
  int pending_count;
  int result_count;
  int overflow_count;
  int idle_cycles = 0;

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  euclid_gcd_lcm_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  egl_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req         (in_req),
    .out_valid      (out_valid),
    .out_res        (out_res),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .result_count   (result_count),
    .overflow_count (overflow_count)
  );

  // Watchdog: too many cycles without a request or a result ends the run.
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic egl_in_t make_pair(logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b);
    egl_in_t req;
    req.first_value  = a;
    req.second_value = b;
    return req;
  endfunction

  function automatic logic [DATA_WIDTH-1:0] rand_value();
    logic [31:0] raw;
    raw = $urandom();
    return raw[DATA_WIDTH-1:0];
  endfunction

  // Random operand pairs drawn from several shapes of the number space.
  function automatic egl_in_t make_random_request();
    int          roll;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] factor;
    logic [63:0] fib_next;
    logic [DATA_WIDTH-1:0] tmp;
    roll = $urandom_range(99);
    if (roll < 30) begin
      a = 64'(rand_value());
      b = 64'(rand_value());
    end else if (roll < 50) begin
      // Shared factor times two cofactors.
      factor = 64'($urandom_range(1023, 1));
      a = factor * 64'($urandom_range(1048575, 1));
      b = factor * 64'($urandom_range(1048575, 1));
    end else if (roll < 65) begin
      a = 64'($urandom_range(100, 1));
      b = 64'($urandom_range(100, 1));
    end else if (roll < 75) begin
      // Products close to the saturation point.
      a = 64'($urandom_range(50000, 40000));
      b = 64'($urandom_range(50000, 40000));
    end else if (roll < 85) begin
      // One operand divides the other.
      a = 64'($urandom_range(32767, 1));
      b = a * 64'($urandom_range(32767, 1));
    end else if (roll < 90) begin
      a = ($urandom_range(1)) ? 64'd0 : 64'(rand_value());
      b = 64'd0;
    end else if (roll < 95) begin
      // Consecutive Fibonacci numbers take the most remainder steps.
      a = 64'd1;
      b = 64'd1;
      repeat ($urandom_range(44, 10)) begin
        fib_next = a + b;
        a = b;
        b = fib_next;
      end
    end else begin
      a = 64'(rand_value());
      b = a;
    end
    tmp = a[DATA_WIDTH-1:0];
    if ($urandom_range(1)) return make_pair(b[DATA_WIDTH-1:0], tmp);
    return make_pair(tmp, b[DATA_WIDTH-1:0]);
  endfunction

  // Mostly short gaps, some long ones, and whole stretches with none.
  function automatic int pick_gap(int item_idx);
    int roll;
    roll = $urandom_range(99);
    if ((item_idx / 40) % 4 == 3) return 0;
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(4, 1);
    if (roll < 97) return $urandom_range(80, 10);
    return $urandom_range(1800, 100);
  endfunction

  // Called at a falling edge; returns just after the edge that takes the request.
  task automatic issue_request(egl_in_t req);
    start  <= 1'b1;
    in_req <= req;
    forever begin
      @(posedge clk);
      if (!busy) break;
      @(negedge clk);
    end
  endtask

  // Ends at a falling edge; start drops only when there is a real gap.
  task automatic idle_gap(int cycles);
    @(negedge clk);
    if (cycles > 0) begin
      start  <= 1'b0;
      in_req <= make_pair(rand_value(), rand_value());
      repeat (cycles) @(negedge clk);
    end
  endtask

  initial begin : stimulus
    egl_in_t directed_reqs[$];
    int      request_count;
    rst_n  = 1'b0;
    start  = 1'b0;
    in_req = '0;
    request_count = 0;

    // Extremes, zero operands, ordering, saturation edges and the
    // longest Euclid chain.
    directed_reqs.push_back(make_pair(31'd1, 31'd1));
    directed_reqs.push_back(make_pair(VALUE_MAX, VALUE_MAX));
    directed_reqs.push_back(make_pair(VALUE_MAX, 31'd1));
    directed_reqs.push_back(make_pair(31'd1, VALUE_MAX));
    directed_reqs.push_back(make_pair(31'd0, 31'd5));
    directed_reqs.push_back(make_pair(31'd7, 31'd0));
    directed_reqs.push_back(make_pair(31'd0, 31'd0));
    directed_reqs.push_back(make_pair(31'd0, VALUE_MAX));
    directed_reqs.push_back(make_pair(VALUE_MAX, VALUE_MAX - 31'd1));
    directed_reqs.push_back(make_pair(31'd12, 31'd18));
    directed_reqs.push_back(make_pair(31'd18, 31'd12));
    directed_reqs.push_back(make_pair(31'd1836311903, 31'd1134903170));
    directed_reqs.push_back(make_pair(31'd1134903170, 31'd1836311903));
    directed_reqs.push_back(make_pair(31'd65536, 31'd65537));
    directed_reqs.push_back(make_pair(31'h4000_0000, 31'd3));
    directed_reqs.push_back(make_pair(31'd46341, 31'd46340));
    directed_reqs.push_back(make_pair(31'd46341, 31'd46342));
    directed_reqs.push_back(make_pair(31'd123456, 31'd123456));
    directed_reqs.push_back(make_pair(31'd1000, 31'd250000));
    directed_reqs.push_back(make_pair(31'h2AAA_AAAA, 31'h5555_5555));
    directed_reqs.push_back(make_pair(31'h4000_0000, 31'h2000_0000));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_reqs[i]) begin
      issue_request(directed_reqs[i]);
      request_count++;
      idle_gap(pick_gap(i));
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      issue_request(make_random_request());
      request_count++;
      idle_gap(pick_gap(i));
    end
    start <= 1'b0;

    // Drain, then watch a while longer for stray results.
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed); %0d results checked, %0d saturated.",
             request_count, directed_reqs.size(), result_count, overflow_count);
    $display("Pairs: zero, equal, dividing, shared-factor, Fibonacci, near overflow.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
